// ----- rtl/core/pshc_pkg.sv -----
package pshc_pkg;

    localparam int CORDIC_N   = 28;
    localparam int ANG_BITS   = 24;
    localparam int CW         = 56;   // CORDIC x/y width
    localparam int ZW         = 36;   // CORDIC angle width
    localparam int ITER_W     = 5;
    localparam logic signed [CW-1:0] CORDIC_K = 56'sd652032874;

    typedef struct packed {
        logic start;
        logic vec;     // 1: vectoring (atan2), 0: rotation (sin/cos)
    } t_cordic_ctl;

    function automatic logic signed [ZW-1:0] atan_deg(input logic [ITER_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 36'sd754974720;
            5'd1:  v = 36'sd445687602;
            5'd2:  v = 36'sd235489088;
            5'd3:  v = 36'sd119537938;
            5'd4:  v = 36'sd60000934;
            5'd5:  v = 36'sd30029717;
            5'd6:  v = 36'sd15018523;
            5'd7:  v = 36'sd7509720;
            5'd8:  v = 36'sd3754917;
            5'd9:  v = 36'sd1877466;
            5'd10: v = 36'sd938734;
            5'd11: v = 36'sd469367;
            5'd12: v = 36'sd234684;
            5'd13: v = 36'sd117342;
            5'd14: v = 36'sd58671;
            5'd15: v = 36'sd29335;
            5'd16: v = 36'sd14668;
            5'd17: v = 36'sd7334;
            5'd18: v = 36'sd3667;
            5'd19: v = 36'sd1833;
            5'd20: v = 36'sd917;
            5'd21: v = 36'sd458;
            5'd22: v = 36'sd229;
            5'd23: v = 36'sd115;
            5'd24: v = 36'sd57;
            5'd25: v = 36'sd29;
            5'd26: v = 36'sd14;
            5'd27: v = 36'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [59:0] v);
        logic [31:0] r;
        if (v > 60'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -60'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/pshc_cordic.sv -----
module pshc_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pshc_pkg::t_cordic_ctl           i_ctl,
    input  logic signed [pshc_pkg::CW-1:0]  i_x0,
    input  logic signed [pshc_pkg::CW-1:0]  i_y0,
    input  logic signed [pshc_pkg::ZW-1:0]  i_z0,
    output logic signed [pshc_pkg::CW-1:0]  o_x,
    output logic signed [pshc_pkg::CW-1:0]  o_y,
    output logic signed [pshc_pkg::ZW-1:0]  o_z,
    output logic                            o_done
);
    import pshc_pkg::*;

    logic signed [CW-1:0] r_x, r_y, n_x, n_y, sx, sy;
    logic signed [ZW-1:0] r_z, n_z, ang;
    logic [ITER_W-1:0]    r_it;
    logic                 r_busy, r_vec, r_done;

    assign sx  = r_x >>> r_it;
    assign sy  = r_y >>> r_it;
    assign ang = atan_deg(r_it);

    // one micro-rotation per cycle
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (r_vec) begin
            if (r_y > 0) begin
                n_x = r_x + sy;
                n_y = r_y - sx;
                n_z = r_z + ang;
            end else if (r_y < 0) begin
                n_x = r_x - sy;
                n_y = r_y + sx;
                n_z = r_z - ang;
            end
        end else begin
            if (r_z >= 0) begin
                n_x = r_x - sy;
                n_y = r_y + sx;
                n_z = r_z - ang;
            end else begin
                n_x = r_x + sy;
                n_y = r_y - sx;
                n_z = r_z + ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_it   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_it   <= '0;
            end else if (r_busy) begin
                r_it <= r_it + 1'b1;
                if (r_it == ITER_W'(CORDIC_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x   <= i_x0;
            r_y   <= i_y0;
            r_z   <= i_z0;
            r_vec <= i_ctl.vec;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_done = r_done;

endmodule

// ----- rtl/core/point_seeking_heading_controller_top.sv -----
// Waypoint-seeking heading controller.
// Input stream: a beat with tuser = 0 loads a start pose from tdata; a beat
// with tuser = 1 advances one control tick. Every input beat yields exactly one
// output beat carrying the pose, step count, path length and arrive/timeout flags.
// Configuration (target, tolerance, step length, gains, limits) is written via
// i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// A load or a tick that takes no step goes straight to the output register. A tick
// that takes a step runs 28 vectoring CORDIC iterations for the bearing, a gain
// multiply, a 32 - FRAC_BITS step modulo-360 reduction, 28 rotation CORDIC
// iterations for sin/cos, and two position multiplies. One shared CORDIC unit
// and one shared multiplier serve all of these steps.
// One item is in flight at a time; s_axis tready is high only while idle.
// The result sits in an output register, so the next item is taken while it
// waits; if the receiver stalls, the following result holds until it drains.
// Reset (synchronous, active low) clears the pose, counters and output valid,
// and returns the configuration registers to their defaults.
module point_seeking_heading_controller_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] start_x, [63:32] start_y, [95:64] start_heading
    input  logic [95:0]  i_s_axis_tdata,
    // [0] kind
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] heading, [111:96] steps_taken,
    // [147:112] path_length, [148] arrived, [149] timed_out, [151:150] zero
    output logic [151:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    import pshc_pkg::*;

    localparam int SH        = ANG_BITS - FRAC_BITS;
    localparam int MOD_STEPS = 32 - FRAC_BITS;
    localparam logic signed [ZW-1:0] ZHALF = (SH == 0) ? '0 : ZW'(1) <<< (SH - 1);
    localparam logic signed [39:0] D90  = 40'sd90  <<< FRAC_BITS;
    localparam logic signed [39:0] D180 = 40'sd180 <<< FRAC_BITS;
    localparam logic signed [39:0] D360 = 40'sd360 <<< FRAC_BITS;

    localparam logic [2:0] REG_TX = 3'd0, REG_TY = 3'd1, REG_TOL = 3'd2, REG_STEP = 3'd3,
                           REG_GH = 3'd4, REG_GL = 3'd5, REG_GSW = 3'd6, REG_LIM = 3'd7;

    localparam logic [3:0] S_IDLE = 4'd0, S_VEC = 4'd1, S_ERR = 4'd2, S_MG = 4'd3,
                           S_HD = 4'd4, S_MOD = 4'd5, S_RED = 4'd6, S_ROT = 4'd7,
                           S_MX = 4'd8, S_AX = 4'd9, S_AY = 4'd10, S_FIN = 4'd11;

    // configuration
    logic signed [31:0] r_tx, r_ty;
    logic [30:0] r_tol;
    logic [19:0] r_step;
    logic [15:0] r_gh, r_gl, r_lim;
    logic [23:0] r_gsw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx   <= 32'sd3276800;
            r_ty   <= 32'sd6553600;
            r_tol  <= 31'd6554;
            r_step <= 20'd6554;
            r_gh   <= 16'd19661;
            r_gl   <= 16'd8192;
            r_gsw  <= 24'd1310720;
            r_lim  <= 16'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TX:   r_tx   <= i_cfg_data;
                REG_TY:   r_ty   <= i_cfg_data;
                REG_TOL:  r_tol  <= i_cfg_data[30:0];
                REG_STEP: r_step <= i_cfg_data[19:0];
                REG_GH:   r_gh   <= i_cfg_data[15:0];
                REG_GL:   r_gl   <= i_cfg_data[15:0];
                REG_GSW:  r_gsw  <= i_cfg_data[23:0];
                REG_LIM:  r_lim  <= i_cfg_data[15:0];
                default:  ;
            endcase
        end
    end

    // pose and sequencer state
    logic [3:0]         r_st;
    logic signed [31:0] r_px, r_py, r_hd;
    logic [15:0]        r_cnt;
    logic [35:0]        r_dist;
    logic signed [35:0] r_err;
    logic [15:0]        r_gain;
    logic signed [56:0] r_prod;
    logic [32:0]        r_mod;
    logic               r_hneg, r_flip;
    logic [4:0]         r_k;
    logic               r_ovalid;
    logic [151:0]       r_odata;

    // near test
    logic signed [32:0] dxs, dys;
    logic [32:0]        adx, ady;
    logic               near, lim_hit;
    assign dxs     = 33'(r_tx) - 33'(r_px);
    assign dys     = 33'(r_ty) - 33'(r_py);
    assign adx     = dxs[32] ? 33'(-dxs) : 33'(dxs);
    assign ady     = dys[32] ? 33'(-dys) : 33'(dys);
    assign near    = (adx <= 33'(r_tol)) && (ady <= 33'(r_tol));
    assign lim_hit = (r_cnt >= r_lim);

    logic in_acc;
    assign o_s_axis_tready = (r_st == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // CORDIC
    t_cordic_ctl        cctl;
    logic signed [CW-1:0] cx0, cy0, cx, cy;
    logic signed [ZW-1:0] cz0, cz;
    logic                 cdone;

    pshc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cctl),
        .i_x0    (cx0),
        .i_y0    (cy0),
        .i_z0    (cz0),
        .o_x     (cx),
        .o_y     (cy),
        .o_z     (cz),
        .o_done  (cdone)
    );

    // vectoring start: fold left half-plane
    logic signed [CW-1:0] vx, vy;
    assign vx = CW'(dxs) <<< 20;
    assign vy = CW'(dys) <<< 20;

    // bearing -> wrapped error
    logic signed [ZW-1:0] brg;
    logic signed [39:0]   e0, e1, e2, aerr;
    assign brg  = (cz + ZHALF) >>> SH;
    assign e0   = 40'(brg) - 40'(r_hd);
    assign e1   = (e0 > D180) ? e0 - D360 : e0;
    assign e2   = (e1 < -D180) ? e1 + D360 : e1;
    assign aerr = e2[39] ? -e2 : e2;

    // heading update
    logic signed [59:0] hsum;
    logic [31:0]        hnew;
    logic signed [32:0] hnew_abs;
    assign hsum     = 60'(r_hd) + 60'((r_prod + 57'sd8192) >>> 14);
    assign hnew     = sat32(hsum);
    assign hnew_abs = hnew[31] ? -33'($signed(hnew)) : 33'($signed(hnew));

    // modulo subtract step
    logic [40:0] msub;
    assign msub = 41'(D360) << r_k;

    // range reduction
    logic signed [39:0] rr0, rr1, rr2;
    logic               fl;
    always_comb begin
        rr0 = (r_hneg && r_mod != '0) ? D360 - 40'(r_mod) : 40'(r_mod);
        rr1 = (rr0 >= D180) ? rr0 - D360 : rr0;
        fl  = 1'b0;
        rr2 = rr1;
        if (rr1 > D90) begin
            rr2 = rr1 - D180;
            fl  = 1'b1;
        end else if (rr1 < -D90) begin
            rr2 = rr1 + D180;
            fl  = 1'b1;
        end
    end

    always_comb begin
        cctl = '0;
        cx0  = CORDIC_K;
        cy0  = '0;
        cz0  = '0;
        if (r_st == S_IDLE) begin
            cctl.start = in_acc && i_s_axis_tuser[0] && !near && !lim_hit;
            cctl.vec   = 1'b1;
            cx0 = vx[CW-1] ? -vx : vx;
            cy0 = vx[CW-1] ? -vy : vy;
            cz0 = vx[CW-1] ? (vy[CW-1] ? -(ZW'(180) <<< ANG_BITS) : (ZW'(180) <<< ANG_BITS))
                           : '0;
        end else if (r_st == S_RED) begin
            cctl.start = 1'b1;
            cz0 = ZW'(rr2 <<< SH);
        end
    end

    // shared multiplier
    logic signed [35:0] ma;
    logic signed [20:0] mb;
    logic signed [35:0] cval, sval;
    assign cval = r_flip ? -cx[35:0] : cx[35:0];
    assign sval = r_flip ? -cy[35:0] : cy[35:0];
    always_comb begin
        case (r_st)
            S_MG:    begin ma = r_err; mb = $signed({5'd0, r_gain}); end
            S_MX:    begin ma = cval;  mb = $signed({1'b0, r_step}); end
            default: begin ma = sval;  mb = $signed({1'b0, r_step}); end
        endcase
    end

    logic signed [59:0] pxs, pys;
    logic [36:0]        dsum;
    assign pxs  = 60'(r_px) + 60'((r_prod + 57'sd536870912) >>> 30);
    assign pys  = 60'(r_py) + 60'((r_prod + 57'sd536870912) >>> 30);
    assign dsum = 37'(r_dist) + 37'(r_step);

    logic out_free;
    assign out_free = !r_ovalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_px     <= '0;
            r_py     <= '0;
            r_hd     <= '0;
            r_cnt    <= '0;
            r_dist   <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_s_axis_tuser[0]) begin
                            r_px   <= i_s_axis_tdata[31:0];
                            r_py   <= i_s_axis_tdata[63:32];
                            r_hd   <= i_s_axis_tdata[95:64];
                            r_cnt  <= '0;
                            r_dist <= '0;
                            r_st   <= S_FIN;
                        end else if (cctl.start) begin
                            r_st <= S_VEC;
                        end else begin
                            r_st <= S_FIN;
                        end
                    end
                end
                S_VEC: if (cdone) r_st <= S_ERR;
                S_ERR: begin
                    r_err  <= e2[35:0];
                    r_gain <= (aerr > 40'(r_gsw)) ? r_gh : r_gl;
                    r_st   <= S_MG;
                end
                S_MG: begin
                    r_prod <= ma * mb;
                    r_st   <= S_HD;
                end
                S_HD: begin
                    r_hd   <= hnew;
                    r_mod  <= hnew_abs;
                    r_hneg <= hnew[31];
                    r_k    <= 5'(MOD_STEPS - 1);
                    r_st   <= S_MOD;
                end
                S_MOD: begin
                    if (41'(r_mod) >= msub) r_mod <= 33'(41'(r_mod) - msub);
                    r_k <= r_k - 1'b1;
                    if (r_k == '0) r_st <= S_RED;
                end
                S_RED: begin
                    r_flip <= fl;
                    r_st   <= S_ROT;
                end
                S_ROT: if (cdone) r_st <= S_MX;
                S_MX: begin
                    r_prod <= ma * mb;
                    r_st   <= S_AX;
                end
                S_AX: begin
                    r_px   <= sat32(pxs);
                    r_prod <= ma * mb;
                    r_st   <= S_AY;
                end
                S_AY: begin
                    r_py   <= sat32(pys);
                    r_cnt  <= r_cnt + 1'b1;
                    r_dist <= dsum[36] ? '1 : dsum[35:0];
                    r_st   <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // result valid: set when a beat is loaded, drop once it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_st == S_FIN && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (r_st == S_FIN && out_free) begin
            r_odata <= {2'b00, !near && lim_hit, near, r_dist, r_cnt, r_hd, r_py, r_px};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule
